>>> rtl/core/ls3_pkg.sv
// ls3_pkg: shared constants and types for the 3x3 pivoting linear solver
// no dependencies

package ls3_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int IO_WIDTH       = 32;
  localparam int CFG_WIDTH      = 31;
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 1;
  localparam logic [CFG_WIDTH-1:0] MIN_PIVOT_RESET = 31'd1;

  // register index
  localparam logic [APB_ADDR_W-1:0] REG_MIN_PIVOT = 1'b0;

  typedef struct packed {
    logic signed [IO_WIDTH-1:0] a00, a01, a02;
    logic signed [IO_WIDTH-1:0] a10, a11, a12;
    logic signed [IO_WIDTH-1:0] a20, a21, a22;
    logic signed [IO_WIDTH-1:0] b0, b1, b2;
  } ls3_in_t;

  typedef struct packed {
    logic signed [IO_WIDTH-1:0] x0, x1, x2;
    logic                       singular;
  } ls3_out_t;

endpackage

>>> rtl/core/ls3_if.sv
// ls3_if: valid/ready stream channel carrying one item
// depends on ls3_pkg

interface ls3_in_if import ls3_pkg::*; ();
  logic    valid;
  logic    ready;
  ls3_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ls3_out_if import ls3_pkg::*; ();
  logic     valid;
  logic     ready;
  ls3_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/linear_solver_3x3_pivoting_top.sv
// linear_solver_3x3_pivoting_top: gauss-jordan solver, partial pivoting
// depends on ls3_pkg and ls3_if
//
// channel  dir  handshake      payload
// in       in   valid/ready    a00..a22, b0..b2
// out      out  valid/ready    x0, x1, x2, singular
// cfg      in   apb            min_pivot at byte 0
//
// one item per cycle while the output does not stall; the pipeline is made of the
// per-column stages (3 columns, each a pivot stage, DW+FB restoring
// divide stages for the 4 quotients, a multiply and a subtract stage).
// each divide stage resolves one quotient bit.
// rst clears valid bits and sets min_pivot to its reset value; a stall at the output freezes
// every stage together, nothing lost or repeated.

module linear_solver_3x3_pivoting_top import ls3_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  ls3_in_if.sink                in_ch,
  ls3_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int DW  = DATA_WIDTH;
  localparam int QW  = DW + FRAC_BITS;      // dividend width
  localparam int NS  = 4;                   // quotients per column
  localparam int LATD = QW;                 // divide steps per column

  typedef logic signed [DW-1:0] val_t;
  typedef val_t [3:0] row_t;
  typedef row_t [2:0] mat_t;

  localparam val_t VMAX = val_t'({1'b0, {(DW-1){1'b1}}});
  localparam val_t VMIN = val_t'({1'b1, {(DW-1){1'b0}}});

  localparam logic signed [IO_WIDTH-1:0] IO_MAX = {1'b0, {(IO_WIDTH-1){1'b1}}};
  localparam logic signed [IO_WIDTH-1:0] IO_MIN = {1'b1, {(IO_WIDTH-1){1'b0}}};

  logic [CFG_WIDTH-1:0] min_pivot;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_MIN_PIVOT) ? APB_DATA_W'(min_pivot) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_pivot <= MIN_PIVOT_RESET;
    end else if (psel && penable && pwrite && paddr == REG_MIN_PIVOT) begin
      min_pivot <= pwdata[CFG_WIDTH-1:0];
    end
  end

  function automatic val_t clamp32(input logic signed [IO_WIDTH-1:0] v);
    logic signed [IO_WIDTH+DW-1:0] w;
    w = (IO_WIDTH+DW)'(v);
    if (w > (IO_WIDTH+DW)'(VMAX)) return VMAX;
    if (w < (IO_WIDTH+DW)'(VMIN)) return VMIN;
    return DW'(w);
  endfunction

  function automatic logic [DW-1:0] mag(input val_t v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  function automatic val_t from_sm(input logic neg, input logic [DW:0] m, input logic ovf);
    if (neg) begin
      if (ovf || m > (DW+1)'(VMAX) + 1'b1) return VMIN;
      return DW'(-m);
    end
    if (ovf || m > (DW+1)'(VMAX)) return VMAX;
    return DW'(m);
  endfunction

  function automatic val_t sub_sat(input val_t a, input val_t b);
    logic signed [DW:0] d;
    d = (DW+1)'(a) - (DW+1)'(b);
    if (d > (DW+1)'(VMAX)) return VMAX;
    if (d < (DW+1)'(VMIN)) return VMIN;
    return DW'(d);
  endfunction

  // stall: everything advances together
  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // per column: pivot stage, LATD divide stages, multiply stage, subtract stage
  localparam int CS = LATD + 3;
  localparam int NST = 3 * CS;

  typedef struct packed {
    logic                 v;
    logic                 sing;
    mat_t                 m;
    logic [NS-1:0]        neg;
    logic [NS-1:0][QW-1:0] num;
    logic [NS-1:0][DW:0]   rem;
    logic [NS-1:0][QW-1:0] quo;
    logic [DW-1:0]        dv;
  } st_t;

  st_t stg_in;
  st_t stg [1:NST];
  logic signed [2*DW-1:0] prod [1:NST][2][4];

  always_comb begin
    stg_in.v = in_ch.valid;
    stg_in.sing = 1'b0;
    stg_in.m[0] = {clamp32(in_ch.data.b0), clamp32(in_ch.data.a02),
                   clamp32(in_ch.data.a01), clamp32(in_ch.data.a00)};
    stg_in.m[1] = {clamp32(in_ch.data.b1), clamp32(in_ch.data.a12),
                   clamp32(in_ch.data.a11), clamp32(in_ch.data.a10)};
    stg_in.m[2] = {clamp32(in_ch.data.b2), clamp32(in_ch.data.a22),
                   clamp32(in_ch.data.a21), clamp32(in_ch.data.a20)};
    stg_in.neg = '0;
    stg_in.num = '0;
    stg_in.rem = '0;
    stg_in.quo = '0;
    stg_in.dv  = '0;
  end

  for (genvar s = 0; s < NST; s++) begin : g_st
    localparam int C = s / CS;
    localparam int P = s % CS;
    st_t cur;
    logic signed [2*DW-1:0] cur_prod [2][4];
    st_t n;
    logic [1:0] pr;
    mat_t sw;
    logic [DW:0] t;
    logic [DW-1:0] pm;
    logic signed [2*DW-1:0] pq [2][4];
    if (s == 0) begin : g_src
      always_comb begin
        cur = stg_in;
        for (int a = 0; a < 2; a++) for (int b = 0; b < 4; b++) cur_prod[a][b] = '0;
      end
    end else begin : g_src
      always_comb begin
        cur = stg[s];
        cur_prod = prod[s];
      end
    end
    always_comb begin
      n = cur;
      pr = '0; sw = n.m; t = '0; pm = '0;
      for (int a = 0; a < 2; a++) for (int b = 0; b < 4; b++) pq[a][b] = '0;
      if (P == 0) begin
        pr = 2'(C);
        for (int r = C + 1; r < 3; r++)
          if (mag(n.m[r][C]) > mag(n.m[pr][C])) pr = 2'(r);
        pm = mag(n.m[pr][C]);
        if (!n.sing && (pm == '0 || {1'b0, pm} < (DW+1)'(min_pivot))) n.sing = 1'b1;
        sw[C] = n.m[pr];
        sw[pr] = n.m[C];
        n.m = sw;
        n.dv = pm;
        for (int j = 0; j < NS; j++) begin
          n.neg[j] = n.m[C][j][DW-1] ^ n.m[C][C][DW-1];
          n.num[j] = {mag(n.m[C][j]), {FRAC_BITS{1'b0}}};
          n.rem[j] = '0;
          n.quo[j] = '0;
        end
      end else if (P <= LATD) begin
        for (int j = 0; j < NS; j++) begin
          t = {n.rem[j][DW-1:0], n.num[j][QW-1]};
          n.num[j] = n.num[j] << 1;
          n.quo[j] = n.quo[j] << 1;
          if (n.dv != '0 && t >= {1'b0, n.dv}) begin
            t = t - {1'b0, n.dv};
            n.quo[j][0] = 1'b1;
          end
          n.rem[j] = t;
        end
        if (P == LATD) begin
          for (int j = 0; j < NS; j++)
            if (j >= C)
              n.m[C][j] = from_sm(n.neg[j], n.quo[j][DW:0],
                                  QW > DW + 1 ? |(n.quo[j] >> (DW + 1)) : 1'b0);
        end
      end else if (P == LATD + 1) begin
        for (int a = 0; a < 2; a++) begin
          for (int j = 0; j < 4; j++) begin
            pq[a][j] = (2*DW)'(mag(n.m[(C + 1 + a) % 3][C])) * (2*DW)'(mag(n.m[C][j]));
          end
        end
      end else begin
        // factor column last, so its sign is still the original one
        for (int a = 0; a < 2; a++) begin
          for (int j = 3; j >= 0; j--) begin
            if (j >= C)
              n.m[(C + 1 + a) % 3][j] = sub_sat(n.m[(C + 1 + a) % 3][j],
                from_sm(n.m[(C + 1 + a) % 3][C][DW-1] ^ n.m[C][j][DW-1],
                        (DW+1)'(cur_prod[a][j] >> FRAC_BITS),
                        |(cur_prod[a][j] >> (DW + FRAC_BITS))));
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        stg[s+1].v <= 1'b0;
      end else if (adv) begin
        stg[s+1].v <= n.v;
      end
      if (adv) begin
        stg[s+1].sing <= n.sing;
        stg[s+1].m    <= n.m;
        stg[s+1].neg  <= n.neg;
        stg[s+1].num  <= n.num;
        stg[s+1].rem  <= n.rem;
        stg[s+1].quo  <= n.quo;
        stg[s+1].dv   <= n.dv;
        for (int a = 0; a < 2; a++) for (int b = 0; b < 4; b++)
          prod[s+1][a][b] <= pq[a][b];
      end
    end
  end

  function automatic logic signed [IO_WIDTH-1:0] to_io(input val_t v, input logic s);
    logic signed [IO_WIDTH+DW-1:0] w;
    w = s ? '0 : (IO_WIDTH+DW)'(v);
    if (w > (IO_WIDTH+DW)'(IO_MAX))
      return IO_MAX;
    if (w < (IO_WIDTH+DW)'(IO_MIN))
      return IO_MIN;
    return IO_WIDTH'(w);
  endfunction

  assign out_ch.valid         = stg[NST].v;
  assign out_ch.data.x0       = to_io(stg[NST].m[0][3], stg[NST].sing);
  assign out_ch.data.x1       = to_io(stg[NST].m[1][3], stg[NST].sing);
  assign out_ch.data.x2       = to_io(stg[NST].m[2][3], stg[NST].sing);
  assign out_ch.data.singular = stg[NST].sing;

endmodule

>>> verif/ls3_solution_checker.sv
// ls3_solution_checker: watches the item channels and the config port of the 3x3 solver,
// predicts each solution by gauss-jordan elimination with partial pivoting and compares
// depends on ls3_pkg

module ls3_solution_checker import ls3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  ls3_in_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  ls3_out_t              out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    fails,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;

  logic [CFG_WIDTH-1:0] pivot_floor;
  ls3_out_t             solutions_due[$];

  function automatic longint magn(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint signed_sat(logic neg, longint m);
    if (neg) return m > VMAX ? VMIN : -m;
    return m > VMAX ? VMAX : m;
  endfunction

  function automatic longint sub_sat(longint a, longint b);
    longint d;
    d = a - b;
    if (d > VMAX) return VMAX;
    if (d < VMIN) return VMIN;
    return d;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = (magn(a) * magn(b)) >>> FRAC_BITS_DEF;
    return signed_sat((a < 0) != (b < 0), p);
  endfunction

  function automatic longint fx_div(longint n, longint d);
    longint q;
    if (d == 0) return n == 0 ? 0 : (n < 0 ? VMIN : VMAX);
    q = (magn(n) << FRAC_BITS_DEF) / magn(d);
    return signed_sat((n < 0) != (d < 0), q);
  endfunction

  function automatic ls3_out_t solve_system(ls3_in_t s, logic [CFG_WIDTH-1:0] floor_v);
    longint   m[3][4];
    longint   t, f, dv, pm;
    int       p;
    logic     sing;
    ls3_out_t o;
    m[0][0] = s.a00; m[0][1] = s.a01; m[0][2] = s.a02; m[0][3] = s.b0;
    m[1][0] = s.a10; m[1][1] = s.a11; m[1][2] = s.a12; m[1][3] = s.b1;
    m[2][0] = s.a20; m[2][1] = s.a21; m[2][2] = s.a22; m[2][3] = s.b2;
    sing = 1'b0;
    for (int c = 0; c < 3 && !sing; c++) begin
      p = c;
      for (int r = c + 1; r < 3; r++)
        if (magn(m[r][c]) > magn(m[p][c])) p = r;
      pm = magn(m[p][c]);
      if (pm == 0 || pm < longint'(floor_v)) begin
        sing = 1'b1;
      end else begin
        if (p != c)
          for (int j = 0; j < 4; j++) begin
            t = m[p][j]; m[p][j] = m[c][j]; m[c][j] = t;
          end
        dv = m[c][c];
        for (int j = c; j < 4; j++) m[c][j] = fx_div(m[c][j], dv);
        for (int r = 0; r < 3; r++)
          if (r != c) begin
            f = m[r][c];
            for (int j = c; j < 4; j++) m[r][j] = sub_sat(m[r][j], fx_mul(f, m[c][j]));
          end
      end
    end
    o.x0 = sing ? '0 : m[0][3][31:0];
    o.x1 = sing ? '0 : m[1][3][31:0];
    o.x2 = sing ? '0 : m[2][3][31:0];
    o.singular = sing;
    return o;
  endfunction

  assign pending = solutions_due.size();

  always @(posedge clk) begin
    ls3_out_t want;
    if (rst) begin
      pivot_floor = MIN_PIVOT_RESET;
      fails = 0;
      solutions_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_MIN_PIVOT)
        pivot_floor = pwdata[CFG_WIDTH-1:0];
      if (in_valid && in_ready)
        solutions_due.push_back(solve_system(in_data, pivot_floor));
      if (out_valid && out_ready) begin
        if (solutions_due.size() == 0) begin
          fails++;
          $display("%0t: unexpected solution %h", $time, out_data);
        end else begin
          want = solutions_due.pop_front();
          if (out_data.x0 !== want.x0) begin
            fails++;
            $display("%0t: x0 expected %h actual %h", $time, want.x0, out_data.x0);
          end
          if (out_data.x1 !== want.x1) begin
            fails++;
            $display("%0t: x1 expected %h actual %h", $time, want.x1, out_data.x1);
          end
          if (out_data.x2 !== want.x2) begin
            fails++;
            $display("%0t: x2 expected %h actual %h", $time, want.x2, out_data.x2);
          end
          if (out_data.singular !== want.singular) begin
            fails++;
            $display("%0t: singular expected %b actual %b", $time, want.singular,
                     out_data.singular);
          end
        end
      end
    end
  end
endmodule

>>> verif/tb_linear_solver_3x3_pivoting_top.sv
// tb_linear_solver_3x3_pivoting_top: drives systems and min_pivot writes into the solver
// under varying back-pressure; verdict from ls3_solution_checker
// depends on ls3_pkg, ls3_if, ls3_solution_checker and the solver rtl

module tb_linear_solver_3x3_pivoting_top;
  import ls3_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 250;
  localparam logic [31:0] QMAX  = 32'h7fffffff;
  localparam logic [31:0] QMIN  = 32'h80000000;
  localparam logic [31:0] ONE   = 32'h00010000;

  logic                  clk;
  logic                  rst;
  logic                  psel, penable, pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    tx_idle, rx_idle;
  logic                  stall_go;
  int                    stall_left;
  int                    quiet;
  int                    fails, pending;

  ls3_in_if  in_ch();
  ls3_out_if out_ch();

  linear_solver_3x3_pivoting_top DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ls3_solution_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_go && stall_left >= 0) begin
      if (stall_left == 0) stall_left = 300;
      stall_left--;
      out_ch.ready <= 1'b0;
      if (stall_left == 0) stall_left = -1;
    end else begin
      out_ch.ready <= $urandom_range(0, 99) >= rx_idle;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet <= 0;
    else if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb_linear_solver_3x3_pivoting_top failed");
      $finish;
    end else
      quiet <= quiet + 1;
  end

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      8: begin
        case ($urandom_range(0, 4))
          0: return QMAX;
          1: return QMIN;
          2: return '0;
          3: return 32'd1;
          default: return '1;
        endcase
      end
      default: return 32'($signed($urandom_range(0, 32)) - 16);
    endcase
  endfunction

  function automatic logic [31:0] rand_small();
    return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
  endfunction

  function automatic ls3_in_t rand_system();
    ls3_in_t s;
    logic [31:0] d;
    if ($urandom_range(0, 99) < 60) begin
      s.a01 = rand_small(); s.a02 = rand_small();
      s.a10 = rand_small(); s.a12 = rand_small();
      s.a20 = rand_small(); s.a21 = rand_small();
      d = 32'($urandom_range(1 << 19, 1 << 21));
      s.a00 = $urandom_range(0, 1) ? d : -d;
      d = 32'($urandom_range(1 << 19, 1 << 21));
      s.a11 = $urandom_range(0, 1) ? d : -d;
      d = 32'($urandom_range(1 << 19, 1 << 21));
      s.a22 = $urandom_range(0, 1) ? d : -d;
      s.b0 = rand_q(); s.b1 = rand_q(); s.b2 = rand_q();
    end else begin
      s = {rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
           rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q()};
    end
    return s;
  endfunction

  task automatic send_system(ls3_in_t s);
    in_ch.valid <= 1'b1;
    in_ch.data  <= s;
    do @(posedge clk); while (!in_ch.ready);
    if ($urandom_range(0, 99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 60);
    end
  endtask

  task automatic write_min_pivot(logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= REG_MIN_PIVOT; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_random(int n);
    repeat (n) send_system(rand_system());
  endtask

  initial begin
    ls3_in_t s;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.data = '0;
    tx_idle = 17; rx_idle = 64; stall_go = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity, zero, extremes, swaps, ties, overflow
    send_system({ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE,
                 ONE, 32'h20000, 32'hfffd0000});
    send_system('0);
    send_system({12{QMAX}});
    send_system({12{QMIN}});
    send_system({32'd0, ONE, 32'd0, ONE, 32'd0, 32'd0, 32'd0, 32'd0, ONE,
                 32'h30000, 32'h50000, 32'h70000});
    send_system({32'hfffe0000, 32'd0, ONE, 32'h20000, ONE, 32'd0, 32'd0, 32'd0, ONE,
                 ONE, ONE, ONE});
    send_system({32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1,
                 QMAX, QMIN, 32'd1});
    send_system({32'd2, 32'd0, 32'd0, 32'd0, 32'd2, 32'd0, 32'd0, 32'd0, 32'd2,
                 QMAX, QMIN, ONE});
    send_system({QMIN, QMAX, QMIN, QMAX, QMIN, QMAX, 32'd1, 32'd2, 32'd3,
                 QMAX, QMIN, QMAX});
    send_system({ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE});
    send_system({32'd0, 32'd0, ONE, 32'd0, ONE, 32'd0, ONE, 32'd0, 32'd0,
                 32'h10, 32'hfffffff0, QMAX});
    send_system({QMAX, 32'd1, 32'd1, 32'd1, QMAX, 32'd1, 32'd1, 32'd1, QMAX,
                 QMIN, QMAX, QMIN});
    send_random(150);
    stall_go <= 1'b1;
    send_random(40);
    drain();

    write_min_pivot(32'd0);
    send_system('0);
    send_system({32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1,
                 ONE, ONE, ONE});
    tx_idle = 64; rx_idle = 17;
    send_random(150);
    drain();

    write_min_pivot({1'b0, {31{1'b1}}});
    send_system({QMAX, 32'd0, 32'd0, 32'd0, QMAX, 32'd0, 32'd0, 32'd0, QMAX,
                 ONE, ONE, ONE});
    send_system({QMIN, 32'd0, 32'd0, 32'd0, QMIN, 32'd0, 32'd0, 32'd0, QMIN,
                 ONE, ONE, ONE});
    send_random(30);
    drain();

    write_min_pivot(32'h8000);
    tx_idle = 0; rx_idle = 0;
    s = {32'h8000, 32'd0, 32'd0, 32'd0, 32'h7fff, 32'd0, 32'd0, 32'd0, ONE,
         ONE, ONE, ONE};
    send_system(s);
    send_random(150);
    drain();

    if (fails == 0 && pending == 0) begin
      $display("tb_linear_solver_3x3_pivoting_top passed");
    end else begin
      $display("tb_linear_solver_3x3_pivoting_top failed");
    end
    $finish;
  end
endmodule
